// File: src/rcem_pkg.sv
// Shared types and constants for the Roberts cross edge magnitude core.
// Used by rcem_ctrl, rcem_datapath and the top level; no dependencies.
package rcem_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int PIXEL_W    = 8;
  localparam int OUT_ROW_W  = 12;
  localparam int OUT_COL_W  = 10;
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = CFG_WIDTH_W'(1024);
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = CFG_HEIGHT_W'(1024);

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // square root: sum of two 16-bit squares fits 17 bits, root fits 9 bits
  localparam int SUM_W      = 17;
  localparam int ROOT_STEPS = 9;
  localparam int STEP_CNT_W = $clog2(ROOT_STEPS);

  // pending result slots, emitted lowest first
  localparam int RES_MAG   = 0;
  localparam int RES_UPPER = 1;
  localparam int RES_CUR   = 2;
  localparam int RES_N     = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;     // input word taken this edge
    logic square;     // line store data valid, form the squares
    logic sum_load;   // load the square root unit
    logic root_step;  // one root digit
    logic pop;        // output word taken this edge
  } cmd_t;

  typedef struct packed {
    logic any_pending;
    logic mag_pending;
    logic one_left;
  } status_t;

endpackage

// File: src/rcem_ctrl.sv
// Sequencer for the edge magnitude core: handshakes, root step count.
// Depends on rcem_pkg.
module rcem_ctrl import rcem_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic [STEP_CNT_W-1:0] step_cnt, step_cnt_next;
  logic root_done;

  assign root_done = (step_cnt == STEP_CNT_W'(ROOT_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        priority if (!status.any_pending) state_next = ST_IDLE;
        else if (status.mag_pending)      state_next = ST_SUM;
        else                              state_next = ST_EMIT;
      end
      ST_SUM: begin
        state_next    = ST_ROOT;
        step_cnt_next = '0;
      end
      ST_ROOT: begin
        if (root_done) state_next = ST_EMIT;
        else step_cnt_next = step_cnt + STEP_CNT_W'(1);
      end
      ST_EMIT: begin
        if (out_ready && status.one_left) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == ST_IDLE);
    out_valid     = (state == ST_EMIT);
    cmd.accept    = in_ready && in_valid;
    cmd.square    = (state == ST_SQUARE);
    cmd.sum_load  = (state == ST_SUM);
    cmd.root_step = (state == ST_ROOT);
    cmd.pop       = out_valid && out_ready;
  end

endmodule

// File: src/rcem_datapath.sv
// Datapath: config registers, line store, window registers, counters,
// squared differences, bit-pair square root and result select. Uses rcem_pkg.
module rcem_datapath import rcem_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [PIXEL_W-1:0]     pixel,
  input  cmd_t                   cmd,
  output status_t                status,
  output logic [OUT_ROW_W-1:0]   out_row,
  output logic [OUT_COL_W-1:0]   out_col,
  output logic [PIXEL_W-1:0]     out_value,
  output logic                   is_copy,
  output logic                   last_of_run
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int CCMPW = ((CW > CFG_WIDTH_W) ? CW : CFG_WIDTH_W) + 1;
  localparam int RCMPW = ((RW > CFG_HEIGHT_W) ? RW : CFG_HEIGHT_W) + 1;
  localparam int ORW   = (RW > OUT_ROW_W) ? RW : OUT_ROW_W;
  localparam int OCW   = (CW > OUT_COL_W) ? CW : OUT_COL_W;
  localparam int SQ_W  = 2 * PIXEL_W;

  logic [CFG_WIDTH_W-1:0]  image_width;
  logic [CFG_HEIGHT_W-1:0] image_height;

  logic [PIXEL_W-1:0] row_store [MAX_WIDTH];
  logic [PIXEL_W-1:0] upper_pixel;  // store read, B of the window
  logic [PIXEL_W-1:0] left_pixel;
  logic [PIXEL_W-1:0] upper_left_pixel;
  logic [RW-1:0]      row_count;
  logic [CW-1:0]      col_count;

  // item under work
  logic [PIXEL_W-1:0] cur_pixel;
  logic [PIXEL_W-1:0] win_a;
  logic [PIXEL_W-1:0] win_c;
  logic [RW-1:0]      cur_row;
  logic [CW-1:0]      cur_col;
  logic [RES_N-1:0]   pending;

  logic [SQ_W-1:0]    sq1, sq2;
  logic [SUM_W-1:0]   rem, root, root_bit;
  logic [SUM_W:0]     trial;

  logic last_col, last_row;
  logic [PIXEL_W-1:0] diff1, diff2;
  logic [PIXEL_W-1:0] mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[CFG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // zero width counts as one column, so only the upper clamp is explicit
  assign last_col = (CCMPW'(col_count) + CCMPW'(1) >= CCMPW'(image_width)) ||
                    (col_count == CW'(MAX_WIDTH - 1));
  assign last_row = (RCMPW'(row_count) + RCMPW'(1) >= RCMPW'(image_height)) ||
                    (row_count == RW'(MAX_HEIGHT - 1));

  // line store, read-first so B is the previous row's pixel
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      upper_pixel          <= row_store[col_count];
      row_store[col_count] <= pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel       <= '0;
      upper_left_pixel <= '0;
      row_count        <= '0;
      col_count        <= '0;
      pending          <= '0;
    end else begin
      if (cmd.accept) begin
        left_pixel <= pixel;
        pending[RES_MAG]   <= (row_count != '0) && (col_count != '0);
        pending[RES_UPPER] <= (row_count != '0) && last_col;
        pending[RES_CUR]   <= last_row;
        if (last_col) begin
          col_count <= '0;
          row_count <= last_row ? '0 : row_count + RW'(1);
        end else begin
          col_count <= col_count + CW'(1);
        end
      end
      if (cmd.square) upper_left_pixel <= upper_pixel;
      if (cmd.pop) pending <= pending & (pending - RES_N'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_pixel <= pixel;
      win_a     <= upper_left_pixel;
      win_c     <= left_pixel;
      cur_row   <= row_count;
      cur_col   <= col_count;
    end
  end

  assign diff1 = (win_a > cur_pixel) ? win_a - cur_pixel : cur_pixel - win_a;
  assign diff2 = (win_c > upper_pixel) ? win_c - upper_pixel : upper_pixel - win_c;

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      sq1 <= SQ_W'(diff1) * SQ_W'(diff1);
      sq2 <= SQ_W'(diff2) * SQ_W'(diff2);
    end
  end

  // digit-by-digit root, one bit pair per cycle
  assign trial = {1'b0, root} + {1'b0, root_bit};

  always_ff @(posedge clk) begin
    if (cmd.sum_load) begin
      rem      <= SUM_W'(sq1) + SUM_W'(sq2);
      root     <= '0;
      root_bit <= SUM_W'(1) << (2 * (ROOT_STEPS - 1));
    end else if (cmd.root_step) begin
      if ({1'b0, rem} >= trial) begin
        rem  <= rem - trial[SUM_W-1:0];
        root <= (root >> 1) + root_bit;
      end else begin
        root <= root >> 1;
      end
      root_bit <= root_bit >> 2;
    end
  end

  assign mag = (root > SUM_W'(255)) ? 8'hFF : root[PIXEL_W-1:0];

  assign status.any_pending = (pending != '0);
  assign status.mag_pending = pending[RES_MAG];
  assign status.one_left    = ((pending & (pending - RES_N'(1))) == '0);

  logic [RW-1:0]  row_sel;
  logic [CW-1:0]  col_sel;
  logic [ORW-1:0] row_wide;
  logic [OCW-1:0] col_wide;

  always_comb begin
    priority if (pending[RES_MAG]) begin
      row_sel   = cur_row - RW'(1);
      col_sel   = cur_col - CW'(1);
      out_value = mag;
      is_copy   = 1'b0;
    end else if (pending[RES_UPPER]) begin
      row_sel   = cur_row - RW'(1);
      col_sel   = cur_col;
      out_value = upper_pixel;
      is_copy   = 1'b1;
    end else begin
      row_sel   = cur_row;
      col_sel   = cur_col;
      out_value = cur_pixel;
      is_copy   = 1'b1;
    end
  end

  assign row_wide    = ORW'(row_sel);
  assign col_wide    = OCW'(col_sel);
  assign out_row     = row_wide[OUT_ROW_W-1:0];
  assign out_col     = col_wide[OUT_COL_W-1:0];
  assign last_of_run = status.one_left;

endmodule

// File: src/roberts_cross_edge_magnitude_core.sv
// Roberts cross edge magnitude core, top level. Uses rcem_pkg, rcem_ctrl
// and rcem_datapath.
// Flow: a taken pixel goes to the square state, then to sum and the 9-step
// root unit when it completes a window, then to emit; with border copies
// only it goes from square to emit, and with nothing to yield to idle. A
// new pixel is taken only in idle; words leave one per cycle with out_ready.
// Reset: counters, window registers and the sequencer clear; the line store
// is not cleared, so there is no startup pass.
module roberts_cross_edge_magnitude_core import rcem_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [PIXEL_W-1:0]     pixel,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_ROW_W-1:0]   out_row,
  output logic [OUT_COL_W-1:0]   out_col,
  output logic [PIXEL_W-1:0]     out_value,
  output logic                   is_copy,
  output logic                   last_of_run
);

  cmd_t    cmd;
  status_t status;

  rcem_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rcem_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel       (pixel),
    .cmd         (cmd),
    .status      (status),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_value   (out_value),
    .is_copy     (is_copy),
    .last_of_run (last_of_run)
  );

endmodule
